/* src/tawp_pkg.sv */
// Shared types and constants for the tile adjacency weighted picker.
// Used by tawp_walk and the top level; depends on nothing.
package tawp_pkg;

   localparam int MAX_RULES_DEF = 16;
   localparam int MAX_WIDTH_DEF = 256;

   localparam int OP_W       = 2;
   localparam int TILE_ID_W  = 10;
   localparam int WEIGHT_W   = 8;
   localparam int MASK_W     = 16;
   localparam int FRAC_W     = 16;
   localparam int GRID_W_W   = 9;
   localparam int GRID_H_W   = 16;
   localparam int COL_OUT_W  = 8;
   localparam int ROW_W      = 16;
   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = 16;

   localparam logic [OP_W-1:0] OP_LOAD  = 2'd0;
   localparam logic [OP_W-1:0] OP_START = 2'd1;
   localparam logic [OP_W-1:0] OP_CELL  = 2'd2;

   localparam logic [CSR_IDX_W-1:0] CSR_GRID_WIDTH  = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_GRID_HEIGHT = 2'd1;

   localparam logic [GRID_W_W-1:0] GRID_W_RESET = 9'd16;
   localparam logic [GRID_H_W-1:0] GRID_H_RESET = 16'd16;

   typedef struct packed {
      logic              present;
      logic [MASK_W-1:0] mask;
   } adj_mask_type;

   typedef struct packed {
      logic [TILE_ID_W-1:0] tile_id;
      logic [WEIGHT_W-1:0]  weight;
      adj_mask_type         below;
      adj_mask_type         right;
   } entry_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_LB_WAIT,
      ST_NB_READ,
      ST_NB_APPLY,
      ST_SUM,
      ST_MUL,
      ST_PICK,
      ST_DONE
   } state_type;

   typedef struct packed {
      logic sum_clear;
      logic sum_acc;
      logic mul_load;
      logic pick_clear;
      logic pick_step;
   } walk_ctrl_type;

endpackage

/* src/tawp_ram.sv */
// Generic single-write, single-read RAM with registered read data.
// Holds the rule table and the row-above line buffer; no package needed.
module tawp_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16,
   parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic             clock,
   input  logic             wr_en,
   input  logic [AW-1:0]    wr_addr,
   input  logic [WIDTH-1:0] wr_data,
   input  logic [AW-1:0]    rd_addr,
   output logic [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

/* src/tawp_walk.sv */
// Shared weight unit: accumulates candidate weights, scales the random target
// and walks it down to the picked entry. Depends on tawp_pkg.
module tawp_walk #(
   parameter int MAX_RULES = tawp_pkg::MAX_RULES_DEF,
   parameter int IW        = (MAX_RULES > 1) ? $clog2(MAX_RULES) : 1
) (
   input  logic                           clock,
   input  logic                           reset,
   input  tawp_pkg::walk_ctrl_type        ctrl,
   input  logic                           cand_bit,
   input  logic [IW-1:0]                  data_idx,
   input  logic [tawp_pkg::WEIGHT_W-1:0]  weight,
   input  logic [tawp_pkg::TILE_ID_W-1:0] tile_id,
   input  logic [tawp_pkg::FRAC_W-1:0]    frac,
   output logic [IW-1:0]                  sel_idx,
   output logic [tawp_pkg::TILE_ID_W-1:0] sel_id
);
   import tawp_pkg::*;

   localparam int TOTW = $clog2(MAX_RULES * ((1 << WEIGHT_W) - 1) + 1);
   localparam int TGTW = TOTW + FRAC_W;

   logic [TOTW-1:0]      total_ff;
   logic [TGTW-1:0]      target_ff;
   logic                 found_ff;
   logic                 first_seen_ff;
   logic [IW-1:0]        pick_idx_ff;
   logic [IW-1:0]        first_idx_ff;
   logic [TILE_ID_W-1:0] pick_id_ff;
   logic [TILE_ID_W-1:0] first_id_ff;
   logic [TGTW-1:0]      scaled_w;
   logic                 hit;

   // weight in units of 1/65536, the scale of the total * fraction target
   assign scaled_w = TGTW'({weight, {FRAC_W{1'b0}}});
   assign hit      = target_ff < scaled_w;

   always_ff @(posedge clock) begin
      if (ctrl.sum_clear) begin
         total_ff <= '0;
      end else if (ctrl.sum_acc && cand_bit) begin
         total_ff <= total_ff + TOTW'(weight);
      end
      if (ctrl.mul_load) begin
         target_ff <= TGTW'(total_ff) * TGTW'(frac);
      end else if (ctrl.pick_step && cand_bit && !found_ff && !hit) begin
         target_ff <= target_ff - scaled_w;
      end
      if (ctrl.pick_step && cand_bit && !found_ff && hit) begin
         pick_idx_ff <= data_idx;
         pick_id_ff  <= tile_id;
      end
      if (ctrl.pick_step && cand_bit && !first_seen_ff) begin
         first_idx_ff <= data_idx;
         first_id_ff  <= tile_id;
      end
   end

   always_ff @(posedge clock) begin
      if (reset || ctrl.pick_clear) begin
         found_ff      <= 1'b0;
         first_seen_ff <= 1'b0;
      end else if (ctrl.pick_step && cand_bit) begin
         first_seen_ff <= 1'b1;
         if (hit) begin
            found_ff <= 1'b1;
         end
      end
   end

   // zero total weight never hits: fall back to the lowest candidate
   assign sel_idx = found_ff ? pick_idx_ff : first_idx_ff;
   assign sel_id  = found_ff ? pick_id_ff  : first_id_ff;

endmodule

/* src/tile_adjacency_weighted_picker_top.sv */
// Tile adjacency weighted picker: scanline tile map generator, top level.
// Load/start items: busy stays low. Cell item: busy through LB_WAIT, NB_READ, NB_APPLY (per usable
// neighbor), SUM, MUL, PICK and DONE; the result strobes the cycle after DONE.
// One rule table read port, walked twice by one adder/compare unit (weight sum, then pick).
// No rules: the error result strobes the cycle after accept. The receiver cannot stall.
// Reset (sync, high) clears count, position and control registers; tables hold garbage until written.
module tile_adjacency_weighted_picker_top #(
   parameter int MAX_RULES = tawp_pkg::MAX_RULES_DEF,
   parameter int MAX_WIDTH = tawp_pkg::MAX_WIDTH_DEF
) (
   input  logic                            clock,
   input  logic                            reset,
   // command channel
   input  logic                            start,
   output logic                            busy,
   input  logic [tawp_pkg::OP_W-1:0]       req_op,
   input  logic [tawp_pkg::TILE_ID_W-1:0]  req_rule_tile_id,
   input  logic [tawp_pkg::WEIGHT_W-1:0]   req_rule_weight,
   input  logic [tawp_pkg::MASK_W-1:0]     req_below_allowed_mask,
   input  logic                            req_below_list_present,
   input  logic [tawp_pkg::MASK_W-1:0]     req_right_allowed_mask,
   input  logic                            req_right_list_present,
   input  logic [tawp_pkg::FRAC_W-1:0]     req_random_fraction,
   // result channel
   output logic                            rsp_valid,
   output logic [tawp_pkg::TILE_ID_W-1:0]  rsp_chosen_tile_id,
   output logic [tawp_pkg::COL_OUT_W-1:0]  rsp_cell_column,
   output logic [tawp_pkg::ROW_W-1:0]      rsp_cell_row,
   output logic                            rsp_last_cell,
   output logic                            rsp_no_rules_error,
   // configuration write channel
   input  logic                            csr_valid,
   output logic                            csr_ready,
   input  logic [tawp_pkg::CSR_IDX_W-1:0]  csr_index,
   input  logic [tawp_pkg::CSR_DATA_W-1:0] csr_wdata
);
   import tawp_pkg::*;

   localparam int IW   = (MAX_RULES > 1) ? $clog2(MAX_RULES) : 1;
   localparam int CNTW = $clog2(MAX_RULES + 1);
   localparam int CW   = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
   localparam int CMPW = ((CW > GRID_W_W) ? CW : GRID_W_W) + 1;
   localparam int EW   = $bits(entry_type);

   // ---------------- registers ----------------
   state_type            state_ff, state_in;
   logic [CNTW-1:0]      entry_count_ff, entry_count_in;
   logic [CW-1:0]        col_ff, col_in;
   logic [ROW_W-1:0]     row_ff, row_in;
   logic [IW-1:0]        left_ff, left_in;
   logic [GRID_W_W-1:0]  grid_w_ff, grid_w_in;
   logic [GRID_H_W-1:0]  grid_h_ff, grid_h_in;
   logic [MAX_RULES-1:0] cand_ff, cand_in;
   logic                 nb_sel_ff, nb_sel_in;     // 0: cell above, 1: cell to the left
   logic [CNTW-1:0]      rd_idx_ff, rd_idx_in;
   logic                 data_vld_ff, data_vld_in;
   logic [IW-1:0]        data_idx_ff, data_idx_in;
   logic [FRAC_W-1:0]    frac_ff, frac_in;
   logic                 rsp_valid_ff, rsp_valid_in;
   logic [TILE_ID_W-1:0] rsp_id_ff, rsp_id_in;
   logic [CW-1:0]        rsp_col_ff, rsp_col_in;
   logic [ROW_W-1:0]     rsp_row_ff, rsp_row_in;
   logic                 rsp_last_ff, rsp_last_in;
   logic                 rsp_err_ff, rsp_err_in;

   // ---------------- combinational ----------------
   logic                 accept;
   logic                 acc_load, acc_start, acc_cell;
   logic                 table_full;
   logic                 ent_we;
   entry_type            ent_wr_data;
   entry_type            ent_q;
   logic [EW-1:0]        ent_rd_data;
   logic [IW-1:0]        ent_rd_addr;
   logic [IW-1:0]        above_idx;
   logic                 lb_we;
   logic [IW-1:0]        nb_idx;
   logic                 nb_use;
   logic                 nb_ok;
   adj_mask_type         nb_mask;
   logic [MAX_RULES-1:0] mask_ext;
   logic [MAX_RULES-1:0] filt;
   logic [MAX_RULES-1:0] cand_init;
   logic                 walk_run;
   logic                 issue;
   logic                 walk_last;
   walk_ctrl_type        walk_ctrl;
   logic [IW-1:0]        sel_idx;
   logic [TILE_ID_W-1:0] sel_id;
   logic [CMPW-1:0]      gw_ext;
   logic [CMPW-1:0]      width_eff;
   logic [GRID_H_W:0]    height_eff;
   logic                 row_end;
   logic                 last;

   assign busy      = (state_ff != ST_IDLE);
   assign accept    = start && !busy;
   assign acc_load  = accept && (req_op == OP_LOAD);
   assign acc_start = accept && (req_op == OP_START);
   assign acc_cell  = accept && (req_op == OP_CELL);
   assign csr_ready = 1'b1;

   // rule table: loads append at the fill count, saturating when full
   assign table_full = (entry_count_ff >= CNTW'(MAX_RULES));
   assign ent_we     = acc_load && !table_full;

   always_comb begin
      ent_wr_data               = '0;
      ent_wr_data.tile_id       = req_rule_tile_id;
      ent_wr_data.weight        = req_rule_weight;
      ent_wr_data.below.mask    = req_below_allowed_mask;
      ent_wr_data.below.present = req_below_list_present;
      ent_wr_data.right.mask    = req_right_allowed_mask;
      ent_wr_data.right.present = req_right_list_present;
   end

   tawp_ram #(
      .WIDTH (EW),
      .DEPTH (MAX_RULES),
      .AW    (IW)
   ) u_rule_ram (
      .clock   (clock),
      .wr_en   (ent_we),
      .wr_addr (entry_count_ff[IW-1:0]),
      .wr_data (ent_wr_data),
      .rd_addr (ent_rd_addr),
      .rd_data (ent_rd_data)
   );

   assign ent_q = entry_type'(ent_rd_data);

   // line buffer: entry picked for each column of the previous row
   tawp_ram #(
      .WIDTH (IW),
      .DEPTH (MAX_WIDTH),
      .AW    (CW)
   ) u_line_buf (
      .clock   (clock),
      .wr_en   (lb_we),
      .wr_addr (col_ff),
      .wr_data (sel_idx),
      .rd_addr (col_ff),
      .rd_data (above_idx)
   );

   // neighbor filter: a stale index or an absent mask leaves the set alone
   assign nb_idx  = nb_sel_ff ? left_ff : above_idx;
   assign nb_use  = nb_sel_ff ? (col_ff != '0) : (row_ff != '0);
   assign nb_ok   = nb_use && (CNTW'(nb_idx) < entry_count_ff);
   assign nb_mask = nb_sel_ff ? ent_q.right : ent_q.below;

   always_comb begin
      for (int i = 0; i < MAX_RULES; i++) begin
         // entry positions past the mask width can never be allowed
         mask_ext[i]  = (i < MASK_W) ? nb_mask.mask[i % MASK_W] : 1'b0;
         cand_init[i] = (CNTW'(i) < entry_count_ff);
      end
   end

   assign filt = cand_ff & mask_ext;

   // table walk: one read issued per cycle, its data returned in the cycle after
   assign walk_run  = (state_ff == ST_SUM) || (state_ff == ST_PICK);
   assign issue     = rd_idx_ff < entry_count_ff;
   assign walk_last = data_vld_ff && (CNTW'(data_idx_ff) == (entry_count_ff - CNTW'(1)));

   tawp_walk #(
      .MAX_RULES (MAX_RULES),
      .IW        (IW)
   ) u_walk (
      .clock    (clock),
      .reset    (reset),
      .ctrl     (walk_ctrl),
      .cand_bit (cand_ff[data_idx_ff]),
      .data_idx (data_idx_ff),
      .weight   (ent_q.weight),
      .tile_id  (ent_q.tile_id),
      .frac     (frac_ff),
      .sel_idx  (sel_idx),
      .sel_id   (sel_id)
   );

   // map geometry: width 0 counts as 1 and is capped at the line buffer size
   assign gw_ext     = CMPW'(grid_w_ff);
   assign width_eff  = (gw_ext == '0) ? CMPW'(1) :
                       ((gw_ext > CMPW'(MAX_WIDTH)) ? CMPW'(MAX_WIDTH) : gw_ext);
   assign height_eff = (grid_h_ff == '0) ? (GRID_H_W+1)'(1) : {1'b0, grid_h_ff};
   assign row_end    = (CMPW'(col_ff) + CMPW'(1)) >= width_eff;
   assign last       = row_end && (({1'b0, row_ff} + (GRID_H_W+1)'(1)) >= height_eff);

   // ---------------- sequencer: next state ----------------
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (acc_cell && (entry_count_ff != '0)) begin
               state_in = ST_LB_WAIT;
            end
         end
         ST_LB_WAIT: begin
            state_in = ST_NB_READ;
         end
         ST_NB_READ: begin
            if (nb_ok) begin
               state_in = ST_NB_APPLY;
            end else if (nb_sel_ff) begin
               state_in = ST_SUM;
            end
         end
         ST_NB_APPLY: begin
            state_in = nb_sel_ff ? ST_SUM : ST_NB_READ;
         end
         ST_SUM: begin
            if (walk_last) begin
               state_in = ST_MUL;
            end
         end
         ST_MUL: begin
            state_in = ST_PICK;
         end
         ST_PICK: begin
            if (walk_last) begin
               state_in = ST_DONE;
            end
         end
         ST_DONE: begin
            state_in = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // ---------------- sequencer: outputs ----------------
   always_comb begin
      ent_rd_addr          = rd_idx_ff[IW-1:0];
      lb_we                = 1'b0;
      walk_ctrl            = '0;
      walk_ctrl.sum_clear  = acc_cell;
      case (state_ff)
         ST_NB_READ: begin
            ent_rd_addr = nb_idx;
         end
         ST_SUM: begin
            walk_ctrl.sum_acc = data_vld_ff;
         end
         ST_MUL: begin
            walk_ctrl.mul_load   = 1'b1;
            walk_ctrl.pick_clear = 1'b1;
         end
         ST_PICK: begin
            walk_ctrl.pick_step = data_vld_ff;
         end
         ST_DONE: begin
            lb_we = 1'b1;
         end
         default: begin
            ent_rd_addr = rd_idx_ff[IW-1:0];
         end
      endcase
   end

   // ---------------- datapath next values ----------------
   always_comb begin
      entry_count_in = entry_count_ff;
      col_in         = col_ff;
      row_in         = row_ff;
      left_in        = left_ff;
      grid_w_in      = grid_w_ff;
      grid_h_in      = grid_h_ff;
      cand_in        = cand_ff;
      nb_sel_in      = nb_sel_ff;
      rd_idx_in      = rd_idx_ff;
      data_vld_in    = walk_run && issue;
      data_idx_in    = rd_idx_ff[IW-1:0];
      frac_in        = frac_ff;
      rsp_valid_in   = 1'b0;
      rsp_id_in      = rsp_id_ff;
      rsp_col_in     = rsp_col_ff;
      rsp_row_in     = rsp_row_ff;
      rsp_last_in    = rsp_last_ff;
      rsp_err_in     = rsp_err_ff;

      if (csr_valid && csr_ready) begin
         if (csr_index == CSR_GRID_WIDTH) begin
            grid_w_in = csr_wdata[GRID_W_W-1:0];
         end else if (csr_index == CSR_GRID_HEIGHT) begin
            grid_h_in = csr_wdata[GRID_H_W-1:0];
         end
      end

      if (ent_we) begin
         entry_count_in = entry_count_ff + CNTW'(1);
      end

      if (acc_start) begin
         col_in  = '0;
         row_in  = '0;
         left_in = '0;
      end

      if (acc_cell) begin
         cand_in = cand_init;
         frac_in = req_random_fraction;
         if (entry_count_ff == '0) begin
            // no rules: error item at the current position, no advance
            rsp_valid_in = 1'b1;
            rsp_id_in    = '0;
            rsp_col_in   = col_ff;
            rsp_row_in   = row_ff;
            rsp_last_in  = 1'b0;
            rsp_err_in   = 1'b1;
         end
      end

      if (state_ff == ST_IDLE) begin
         nb_sel_in = 1'b0;
      end else if ((state_ff == ST_NB_READ) && !nb_ok) begin
         nb_sel_in = 1'b1;
      end else if (state_ff == ST_NB_APPLY) begin
         nb_sel_in = 1'b1;
         // a filter that would empty the set is skipped
         if (nb_mask.present && (filt != '0)) begin
            cand_in = filt;
         end
      end

      if (walk_run && issue) begin
         rd_idx_in = rd_idx_ff + CNTW'(1);
      end else if ((state_ff == ST_IDLE) || (state_ff == ST_MUL)) begin
         rd_idx_in = '0;
      end

      if (state_ff == ST_DONE) begin
         left_in      = sel_idx;
         rsp_valid_in = 1'b1;
         rsp_id_in    = sel_id;
         rsp_col_in   = col_ff;
         rsp_row_in   = row_ff;
         rsp_last_in  = last;
         rsp_err_in   = 1'b0;
         if (last) begin
            col_in = '0;
            row_in = '0;
         end else if (row_end) begin
            col_in = '0;
            row_in = row_ff + ROW_W'(1);
         end else begin
            col_in = col_ff + CW'(1);
         end
      end
   end

   // ---------------- registers ----------------
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= ST_IDLE;
         entry_count_ff <= '0;
         col_ff         <= '0;
         row_ff         <= '0;
         left_ff        <= '0;
         grid_w_ff      <= GRID_W_RESET;
         grid_h_ff      <= GRID_H_RESET;
         nb_sel_ff      <= 1'b0;
         rd_idx_ff      <= '0;
         data_vld_ff    <= 1'b0;
         rsp_valid_ff   <= 1'b0;
      end else begin
         state_ff       <= state_in;
         entry_count_ff <= entry_count_in;
         col_ff         <= col_in;
         row_ff         <= row_in;
         left_ff        <= left_in;
         grid_w_ff      <= grid_w_in;
         grid_h_ff      <= grid_h_in;
         nb_sel_ff      <= nb_sel_in;
         rd_idx_ff      <= rd_idx_in;
         data_vld_ff    <= data_vld_in;
         rsp_valid_ff   <= rsp_valid_in;
      end
   end

   // payload, no reset
   always_ff @(posedge clock) begin
      cand_ff     <= cand_in;
      data_idx_ff <= data_idx_in;
      frac_ff     <= frac_in;
      rsp_id_ff   <= rsp_id_in;
      rsp_col_ff  <= rsp_col_in;
      rsp_row_ff  <= rsp_row_in;
      rsp_last_ff <= rsp_last_in;
      rsp_err_ff  <= rsp_err_in;
   end

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_chosen_tile_id = rsp_id_ff;
   assign rsp_cell_column    = COL_OUT_W'(rsp_col_ff);
   assign rsp_cell_row       = rsp_row_ff;
   assign rsp_last_cell      = rsp_last_ff;
   assign rsp_no_rules_error = rsp_err_ff;

   // ---------------- assertions ----------------
   // the rule table only grows on an accepted load
   a_count_stable_busy: assert property (@(posedge clock) disable iff (reset)
      busy |=> $stable(entry_count_ff))
      else $error("rule count changed while a cell item was in flight");

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      entry_count_ff <= CNTW'(MAX_RULES))
      else $error("rule count past table size");

   // a normal result only follows the end of a walk
   a_rsp_from_done: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_no_rules_error) |-> ($past(state_ff) == ST_DONE))
      else $error("cell item result without a completed walk");

   a_err_payload: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_no_rules_error) |-> ((rsp_chosen_tile_id == '0) && !rsp_last_cell))
      else $error("error item carries a tile or a last flag");

endmodule
